// File: hw/rtl/rbca_pkg.sv
`timescale 1ns / 1ps

package rbca_pkg;

  // retransmit store geometry
  localparam int unsigned BUFFER_DEPTH = 32;
  localparam int unsigned PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SUM_W        = CNT_W + 1;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned ENTRY_W = SEQ_W + CODE_W;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command selector codes
  localparam logic [CMD_W-1:0] CMD_PUSH = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_ACK  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_EMIT = CMD_W'(2);

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_ACK,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] arg;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PURGE_RD,
    ST_PURGE_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EMPTY_OUT
  } back_state_e;

  // circular slot arithmetic, base below depth and offset at most depth
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(BUFFER_DEPTH)) begin
      sum = sum - SUM_W'(BUFFER_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/retransmit_buffer_cumulative_ack.sv
`timescale 1ns / 1ps

// channel  direction  handshake                payload
// in       sink       in_valid_i/in_stall_o    cmd_i, command_code_i, ack_index_i
// out      source     out_valid_o/out_stall_i  entry_valid_o, entry_sequence_o,
//                                              entry_command_o, last_o, pending_o
//
// push and acknowledge are handled in the idle state of the back part
// an emit leaves the queue in the idle state, then each acked head entry is read and purged,
// the first live entry is checked or the empty result sent, then each entry is read and sent (registered store read)
// while out_stall_i holds a waiting result, the emit waits until the output is free
// reset clears pointers, counters and sequence numbers; the store itself is not cleared
// a two-entry queue takes transfers until it is full while the back part works or the output waits

module retransmit_buffer_cumulative_ack import rbca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [CODE_W-1:0] command_code_i,
  input  logic [SEQ_W-1:0]  ack_index_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              entry_valid_o,
  output logic [SEQ_W-1:0]  entry_sequence_o,
  output logic [CODE_W-1:0] entry_command_o,
  output logic              last_o,
  output logic              pending_o
);

  // front to queue
  logic  q_push, q_full;
  item_t q_in_item;

  // queue to back
  logic  q_valid, q_pop;
  item_t q_out_item;

  // decode, drop unused selector codes
  rbca_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .command_code_i (command_code_i),
    .ack_index_i    (ack_index_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in_item)
  );

  // decoupling queue
  rbca_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_out_item)
  );

  // store, purge and emit sequencer
  rbca_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_out_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_valid_o    (entry_valid_o),
    .entry_sequence_o (entry_sequence_o),
    .entry_command_o  (entry_command_o),
    .last_o           (last_o),
    .pending_o        (pending_o)
  );

endmodule

// File: hw/rtl/rbca_ram.sv
`timescale 1ns / 1ps

module rbca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rbca_front.sv
`timescale 1ns / 1ps

module rbca_front import rbca_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [CODE_W-1:0] command_code_i,
  input  logic [SEQ_W-1:0]  ack_index_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output item_t             q_item_o
);

  logic keep;

  // decode the selector, unused codes are taken and dropped here
  always_comb begin
    keep         = 1'b1;
    q_item_o.op  = OP_PUSH;
    q_item_o.arg = SEQ_W'(command_code_i);
    case (cmd_i)
      CMD_PUSH: begin
        q_item_o.op  = OP_PUSH;
        q_item_o.arg = SEQ_W'(command_code_i);
      end
      CMD_ACK: begin
        q_item_o.op  = OP_ACK;
        q_item_o.arg = ack_index_i;
      end
      CMD_EMIT: begin
        q_item_o.op  = OP_EMIT;
        q_item_o.arg = ack_index_i;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

// File: hw/rtl/rbca_fifo.sv
`timescale 1ns / 1ps

module rbca_fifo import rbca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// File: hw/rtl/rbca_back.sv
`timescale 1ns / 1ps

module rbca_back import rbca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              entry_valid_o,
  output logic [SEQ_W-1:0]  entry_sequence_o,
  output logic [CODE_W-1:0] entry_command_o,
  output logic              last_o,
  output logic              pending_o
);

  back_state_e state_q, state_d;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [SEQ_W-1:0] last_q, last_d;
  logic [SEQ_W-1:0] acked_q, acked_d;

  logic              ov_q, ov_d;
  logic              oev_q, oev_d;
  logic [SEQ_W-1:0]  oseq_q, oseq_d;
  logic [CODE_W-1:0] ocmd_q, ocmd_d;
  logic              olast_q, olast_d;
  logic              opend_q, opend_d;

  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [SEQ_W-1:0]   rd_seq;
  logic [CODE_W-1:0]  rd_cmd;

  logic out_free, is_full, is_empty, head_acked, at_last;

  assign out_free   = !ov_q || !out_stall_i;
  assign is_full    = (count_q == CNT_W'(BUFFER_DEPTH));
  assign is_empty   = (count_q == '0);
  assign rd_seq     = ram_rdata[ENTRY_W-1:CODE_W];
  assign rd_cmd     = ram_rdata[CODE_W-1:0];
  assign head_acked = (rd_seq <= acked_q);
  assign at_last    = ((idx_q + CNT_W'(1)) == count_q);

  rbca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_item_i.op == OP_EMIT) begin
          state_d = ST_PURGE_RD;
        end
      end
      ST_PURGE_RD: begin
        state_d = is_empty ? ST_EMPTY_OUT : ST_PURGE_CHK;
      end
      ST_PURGE_CHK: begin
        state_d = head_acked ? ST_PURGE_RD : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          state_d = at_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMPTY_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    last_d    = last_q;
    acked_d   = acked_q;
    ov_d      = ov_q && out_stall_i;
    oev_d     = oev_q;
    oseq_d    = oseq_q;
    ocmd_d    = ocmd_q;
    olast_d   = olast_q;
    opend_d   = opend_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = is_full ? head_q : slot_add(head_q, count_q);
    ram_wdata = {last_q + SEQ_W'(1), q_item_i.arg[CODE_W-1:0]};
    ram_re    = 1'b0;
    ram_raddr = head_q;
    case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          case (q_item_i.op)
            OP_PUSH: begin
              ram_we = 1'b1;
              last_d = last_q + SEQ_W'(1);
              if (is_full) begin
                head_d = slot_add(head_q, CNT_W'(1));
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_ACK: begin
              if (q_item_i.arg > acked_q) begin
                acked_d = q_item_i.arg;
              end
            end
            default: begin
              idx_d = '0;
            end
          endcase
        end
      end
      ST_PURGE_RD: begin
        ram_re = !is_empty;
      end
      ST_PURGE_CHK: begin
        idx_d = '0;
        if (head_acked) begin
          head_d  = slot_add(head_q, CNT_W'(1));
          count_d = count_q - CNT_W'(1);
        end
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = slot_add(head_q, idx_q);
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oev_d   = 1'b1;
          oseq_d  = rd_seq;
          ocmd_d  = rd_cmd;
          olast_d = at_last;
          opend_d = (acked_q != last_q);
          idx_d   = idx_q + CNT_W'(1);
        end
      end
      ST_EMPTY_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oev_d   = 1'b0;
          oseq_d  = '0;
          ocmd_d  = '0;
          olast_d = 1'b1;
          opend_d = (acked_q != last_q);
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      last_q  <= '0;
      acked_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      acked_q <= acked_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oev_q   <= oev_d;
    oseq_q  <= oseq_d;
    ocmd_q  <= ocmd_d;
    olast_q <= olast_d;
    opend_q <= opend_d;
  end

  assign out_valid_o      = ov_q;
  assign entry_valid_o    = oev_q;
  assign entry_sequence_o = oseq_q;
  assign entry_command_o  = ocmd_q;
  assign last_o           = olast_q;
  assign pending_o        = opend_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(BUFFER_DEPTH))
    else $error("entry count above buffer depth");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !oev_q) |-> olast_q)
    else $error("empty result not marked last");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_OUT) |-> (idx_q < count_q))
    else $error("emit index beyond held entries");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && q_valid_i && q_item_i.op == OP_PUSH) |=> !is_empty)
    else $error("store empty after a push");
`endif

endmodule

// File: test/retransmit_buffer_cumulative_ack_test.sv
`timescale 1ns / 1ps

module retransmit_buffer_cumulative_ack_test;
  import rbca_pkg::*;

  // selector value the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);

  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned RANDOM_ITEMS  = 305;
  // longest quiet spell: a full purge of the store plus stall runs, several times over
  localparam int unsigned QUIET_LIMIT   = 2000;
  // cycles left after the last result for stray output to show up
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam logic [SEQ_W-1:0] SEQ_MAX  = '1;

  // one command waiting to go into the block
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] code;
    logic [SEQ_W-1:0]  ack;
    bit                drain_first;  // hold back until every resend has come out
    bit                calm;         // no idling on either side while this is in play
  } command_t;

  // one resend result as the block reports it
  typedef struct packed {
    logic              present;
    logic [SEQ_W-1:0]  seq;
    logic [CODE_W-1:0] code;
    logic              last;
    logic              pend;
  } resend_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  cmd_i          = CMD_PUSH;
  logic [CODE_W-1:0] command_code_i = '0;
  logic [SEQ_W-1:0]  ack_index_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              entry_valid_o;
  logic [SEQ_W-1:0]  entry_sequence_o;
  logic [CODE_W-1:0] entry_command_o;
  logic              last_o;
  logic              pending_o;

  retransmit_buffer_cumulative_ack DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .command_code_i   (command_code_i),
    .ack_index_i      (ack_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_valid_o    (entry_valid_o),
    .entry_sequence_o (entry_sequence_o),
    .entry_command_o  (entry_command_o),
    .last_o           (last_o),
    .pending_o        (pending_o)
  );

  always #5 clk_i = ~clk_i;

  command_t command_q[$];
  resend_t  resend_q[$];      // resends still owed by the block, oldest first
  int unsigned results_owed = 0;  // size of resend_q as of the previous edge
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor: a ring of issued commands, the last issued and the acked number
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0]  ring_seq [BUFFER_DEPTH];
  logic [CODE_W-1:0] ring_code [BUFFER_DEPTH];
  int unsigned       ring_head  = 0;
  int unsigned       ring_count = 0;
  logic [SEQ_W-1:0]  issued_seq = '0;
  logic [SEQ_W-1:0]  acked_seq  = '0;

  task automatic track_command(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                               input logic [SEQ_W-1:0] ack);
    int unsigned slot;
    int unsigned i;
    logic pend;
    resend_t item;
    case (cmd)
      CMD_PUSH: begin
        // a full ring loses its oldest entry to make room
        if (ring_count >= BUFFER_DEPTH) begin
          ring_head  = (ring_head + 1) % BUFFER_DEPTH;
          ring_count = BUFFER_DEPTH - 1;
        end
        issued_seq = issued_seq + 1'b1;
        slot = (ring_head + ring_count) % BUFFER_DEPTH;
        ring_seq[slot]  = issued_seq;
        ring_code[slot] = code;
        ring_count++;
      end
      CMD_ACK: begin
        // cumulative: the acked number only ever rises
        if (ack > acked_seq) begin
          acked_seq = ack;
        end
      end
      CMD_EMIT: begin
        // pending is judged before the purge
        pend = (acked_seq != issued_seq);
        while (ring_count > 0 && ring_seq[ring_head] <= acked_seq) begin
          ring_head = (ring_head + 1) % BUFFER_DEPTH;
          ring_count--;
        end
        if (ring_count == 0) begin
          item = '{1'b0, SEQ_W'(0), CODE_W'(0), 1'b1, pend};
          resend_q.insert(resend_q.size(), item);
        end else begin
          for (i = 0; i < ring_count; i++) begin
            slot = (ring_head + i) % BUFFER_DEPTH;
            item = '{1'b1, ring_seq[slot], ring_code[slot], i + 1 == ring_count, pend};
            resend_q.insert(resend_q.size(), item);
          end
        end
      end
      default: begin
        // unused selector leaves everything alone
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents the queued commands, idling at random outside calm stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_commands
    command_t next;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      cmd_i          <= CMD_PUSH;
      command_code_i <= '0;
      ack_index_i    <= '0;
      calm           <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      // a held-back command waits for an empty input slot and no resends owed;
      // results_owed is registered from the previous edge, hence the empty slot first
      if (command_q.size() != 0 &&
          !(command_q[0].drain_first && (in_valid_i || results_owed != 0)) &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next = command_q[0];
        command_q.delete(0);
        in_valid_i     <= 1'b1;
        cmd_i          <= next.cmd;
        command_code_i <= next.code;
        ack_index_i    <= next.ack;
        calm           <= next.calm;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver side stalls at random, never during a calm stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each resend transfer, then feeds accepted commands to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_transfers
    resend_t got;
    resend_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{entry_valid_o, entry_sequence_o, entry_command_o, last_o, pending_o};
        if (resend_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual valid=%0b seq=%0h %s",
                   $time, got.present, got.seq, "");
          $display("  actual code=%0h last=%0b pending=%0b", got.code, got.last, got.pend);
        end else begin
          want = resend_q[0];
          resend_q.delete(0);
          if (got !== want) begin
            errors++;
            $write("%0t: mismatch, expected valid=%0b seq=%0h code=%0h last=%0b pending=%0b",
                   $time, want.present, want.seq, want.code, want.last, want.pend);
            $display(", actual valid=%0b seq=%0h code=%0h last=%0b pending=%0b",
                     got.present, got.seq, got.code, got.last, got.pend);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        track_command(cmd_i, command_code_i, ack_index_i);
      end
      results_owed <= resend_q.size();
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus planning, with a rough copy of issued and acked numbers so that
  // acknowledges land inside the live window
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0] plan_issued = '0;
  logic [SEQ_W-1:0] plan_acked  = '0;
  int unsigned      plan_count  = 0;
  bit               plan_drain  = 1'b0;
  bit               plan_calm   = 1'b0;

  task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                               input logic [SEQ_W-1:0] ack);
    command_t entry;
    entry = '{cmd, code, ack, plan_drain, plan_calm};
    command_q.insert(command_q.size(), entry);
    plan_drain = 1'b0;
    if (cmd == CMD_PUSH) begin
      plan_issued++;
    end
    if (cmd == CMD_ACK && ack > plan_acked) begin
      plan_acked = ack;
    end
    // ignored commands do not count towards the random total
    if (cmd != CMD_UNUSED) begin
      plan_count++;
    end
  endtask

  function automatic logic [SEQ_W-1:0] pick_ack();
    int unsigned pick = $urandom_range(9);
    int unsigned back = $urandom_range(8);
    // mostly somewhere in the unacknowledged window
    if (pick < 7) begin
      return (plan_issued > back) ? plan_issued - back : '0;
    end
    // stale acknowledge, no effect
    if (pick < 9) begin
      return (plan_acked > back) ? plan_acked - back : '0;
    end
    // a little ahead of issue
    return plan_issued + $urandom_range(1, 3);
  endfunction

  initial begin : run_test
    int unsigned burst;
    // directed: empty emit, code extremes, stale and ahead acknowledges,
    // ignored selector, purge at the head
    queue_command(CMD_EMIT, 8'h00, '0);
    queue_command(CMD_PUSH, 8'h00, '0);
    queue_command(CMD_PUSH, 8'hFF, '0);
    queue_command(CMD_PUSH, 8'h5A, '0);
    queue_command(CMD_EMIT, 8'hFF, SEQ_MAX);
    queue_command(CMD_ACK, 8'h00, 32'd0);
    queue_command(CMD_ACK, 8'h00, 32'd2);
    queue_command(CMD_EMIT, 8'h00, '0);
    queue_command(CMD_UNUSED, 8'hFF, SEQ_MAX);
    queue_command(CMD_ACK, 8'h00, 32'd1);
    queue_command(CMD_ACK, 8'h00, 32'd3);
    queue_command(CMD_EMIT, 8'h00, '0);
    queue_command(CMD_ACK, 8'h00, 32'd6);
    queue_command(CMD_EMIT, 8'h00, '0);
    queue_command(CMD_PUSH, 8'h81, '0);
    queue_command(CMD_PUSH, 8'h7E, '0);
    repeat (3) queue_command(CMD_PUSH, 8'($urandom_range(255)), '0);
    queue_command(CMD_EMIT, 8'h00, '0);
    queue_command(CMD_ACK, 8'h00, 32'd8);
    plan_drain = 1'b1;
    queue_command(CMD_EMIT, 8'h00, '0);

    // random: mostly push bursts followed by an acknowledge and an emit;
    // the odd burst overflows the store, fields that a command ignores carry noise
    plan_count = 0;
    while (plan_count < RANDOM_ITEMS) begin
      plan_calm = (plan_count >= 150 && plan_count < 230);
      if ($urandom_range(39) == 0) begin
        plan_drain = 1'b1;
      end
      case ($urandom_range(19))
        0: begin
          queue_command(CMD_UNUSED, 8'($urandom_range(255)), $urandom());
        end
        1, 2, 3: begin
          queue_command(CMD_W'($urandom_range(2)), 8'($urandom_range(255)), pick_ack());
        end
        default: begin
          burst = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 6);
          repeat (burst) queue_command(CMD_PUSH, 8'($urandom_range(255)), $urandom());
          if ($urandom_range(9) < 7) begin
            queue_command(CMD_ACK, 8'($urandom_range(255)), pick_ack());
          end
          queue_command(CMD_EMIT, 8'($urandom_range(255)), $urandom());
        end
      endcase
    end

    // tail: full-range acknowledges push the acked number far ahead, so they come last
    plan_calm = 1'b0;
    repeat (6) begin
      queue_command(CMD_PUSH, 8'($urandom_range(255)), $urandom());
      queue_command(CMD_ACK, 8'($urandom_range(255)), $urandom());
      queue_command(CMD_EMIT, 8'($urandom_range(255)), $urandom());
    end
    queue_command(CMD_ACK, 8'hFF, SEQ_MAX);
    queue_command(CMD_PUSH, 8'hFF, SEQ_MAX);
    queue_command(CMD_EMIT, 8'hFF, SEQ_MAX);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (command_q.size() != 0 || in_valid_i || results_owed != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
